>>> hw/rtl/pets_pkg.sv
`timescale 1ns / 1ps

package pets_pkg;

   // pins per port: one 8-bit port is masked by 0xff
   localparam int PINS_PER_PORT = 8;

   localparam int DEF_PORT_COUNT = 3;
   localparam int DEF_TIME_BITS  = 32;

   localparam int NOW_TIME_W  = 32;
   localparam int PIN_INDEX_W = 5;
   localparam int STATUS_W    = 2;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_status_type;

   // what the pin bank does with the beat in the work stage
   typedef struct packed {
      logic sample;
      logic query;
   } bank_op_type;

endpackage

>>> hw/rtl/pets_pin_bank.sv
`timescale 1ns / 1ps

module pets_pin_bank #(
   parameter int PIN_COUNT = pets_pkg::PINS_PER_PORT * pets_pkg::DEF_PORT_COUNT,
   parameter int TIME_BITS = pets_pkg::DEF_TIME_BITS,
   parameter int PIN_IDX_W = $clog2(PIN_COUNT)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pets_pkg::bank_op_type     op,
   input  logic [PIN_COUNT-1:0]      levels,
   input  logic [TIME_BITS-1:0]      stamp,
   input  logic [PIN_IDX_W-1:0]      pin_sel,
   output pets_pkg::edge_status_type rd_status,
   output logic [TIME_BITS-1:0]      rd_rise,
   output logic [TIME_BITS-1:0]      rd_fall
);
   import pets_pkg::*;

   logic [PIN_COUNT-1:0] prev_ff;
   logic [PIN_COUNT-1:0] prev_in;
   logic [PIN_COUNT-1:0] changed;
   edge_status_type      status_ff [PIN_COUNT];
   edge_status_type      status_in [PIN_COUNT];
   logic [TIME_BITS-1:0] rise_ff   [PIN_COUNT];
   logic [TIME_BITS-1:0] rise_in   [PIN_COUNT];
   logic [TIME_BITS-1:0] fall_ff   [PIN_COUNT];
   logic [TIME_BITS-1:0] fall_in   [PIN_COUNT];

   assign changed   = prev_ff ^ levels;
   assign rd_status = status_ff[pin_sel];
   assign rd_rise   = rise_ff[pin_sel];
   assign rd_fall   = fall_ff[pin_sel];

   always_comb begin
      prev_in   = prev_ff;
      status_in = status_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      if (op.sample) begin
         prev_in = levels;
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (changed[p]) begin
               if (levels[p]) begin
                  rise_in[p]   = stamp;
                  status_in[p] = EDGE_RISE;
               end else begin
                  fall_in[p]   = stamp;
                  status_in[p] = EDGE_FALL;
               end
            end
         end
      end
      // read-and-clear of the queried pin
      if (op.query) begin
         status_in[pin_sel] = EDGE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '1;
         for (int p = 0; p < PIN_COUNT; p++) begin
            status_ff[p] <= EDGE_NONE;
            rise_ff[p]   <= '0;
            fall_ff[p]   <= '0;
         end
      end else begin
         prev_ff   <= prev_in;
         status_ff <= status_in;
         rise_ff   <= rise_in;
         fall_ff   <= fall_in;
      end
   end

`ifndef SYNTH
   a_query_clears: assert property (@(posedge clock) disable iff (reset)
      op.query |=> status_ff[$past(pin_sel)] == EDGE_NONE)
      else $error("queried pin status not cleared");

   a_sample_tracks_levels: assert property (@(posedge clock) disable iff (reset)
      op.sample |=> prev_ff == $past(levels))
      else $error("previous levels not updated by sample");
`endif

endmodule

>>> hw/rtl/pin_edge_timestamp_capture_core.sv
`timescale 1ns / 1ps
// a query's result beat goes through the work register, then the result register,
// before it is offered; sample beats give no result
// throughput: one beat per cycle, set by the single work stage; a query stalls
// only while the result register holds an untaken beat
// reset (synchronous): previous levels to all ones, pin statuses and both
// timestamps to zero, work and result stages empty

module pin_edge_timestamp_capture_core #(
   parameter int  PORT_COUNT = pets_pkg::DEF_PORT_COUNT,
   parameter int  TIME_BITS  = pets_pkg::DEF_TIME_BITS,
   localparam int PIN_COUNT  = pets_pkg::PINS_PER_PORT * PORT_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [PIN_COUNT-1:0]              req_pin_levels,
   input  logic [pets_pkg::NOW_TIME_W-1:0]   req_now_time,
   input  logic [pets_pkg::PIN_INDEX_W-1:0]  req_pin_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pets_pkg::STATUS_W-1:0]     rsp_edge_status,
   output logic [pets_pkg::NOW_TIME_W-1:0]   rsp_rise_time,
   output logic [pets_pkg::NOW_TIME_W-1:0]   rsp_fall_time
);
   import pets_pkg::*;

   localparam int PIN_IDX_W = $clog2(PIN_COUNT);

   // work stage
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s1_kind_ff;
   logic [PIN_COUNT-1:0]   s1_levels_ff;
   logic [TIME_BITS-1:0]   s1_stamp_ff;
   logic [PIN_INDEX_W-1:0] s1_index_ff;

   // result stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [NOW_TIME_W-1:0]  rsp_rise_ff;
   logic [NOW_TIME_W-1:0]  rsp_fall_ff;

   logic                   req_take;
   logic                   advance;
   logic                   rsp_load;
   logic [PIN_IDX_W-1:0]   pin_sel;
   bank_op_type            op;
   edge_status_type        rd_status;
   logic [TIME_BITS-1:0]   rd_rise;
   logic [TIME_BITS-1:0]   rd_fall;

   // a sample never needs the result register
   assign advance   = s1_valid_ff
                      && (s1_kind_ff == KIND_SAMPLE || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = advance && s1_kind_ff == KIND_QUERY;

   assign op.sample = advance && s1_kind_ff == KIND_SAMPLE;
   assign op.query  = rsp_load;

   assign pin_sel = (int'(s1_index_ff) > PIN_COUNT - 1) ? PIN_IDX_W'(PIN_COUNT - 1)
                                                        : PIN_IDX_W'(s1_index_ff);

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   pets_pin_bank #(
      .PIN_COUNT (PIN_COUNT),
      .TIME_BITS (TIME_BITS),
      .PIN_IDX_W (PIN_IDX_W)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .levels    (s1_levels_ff),
      .stamp     (s1_stamp_ff),
      .pin_sel   (pin_sel),
      .rd_status (rd_status),
      .rd_rise   (rd_rise),
      .rd_fall   (rd_fall)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff   <= req_kind;
         s1_levels_ff <= req_pin_levels;
         s1_stamp_ff  <= TIME_BITS'(req_now_time);
         s1_index_ff  <= req_pin_index;
      end
      if (rsp_load) begin
         rsp_status_ff <= STATUS_W'(rd_status);
         rsp_rise_ff   <= NOW_TIME_W'(rd_rise);
         rsp_fall_ff   <= NOW_TIME_W'(rd_fall);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_edge_status = rsp_status_ff;
   assign rsp_rise_time   = rsp_rise_ff;
   assign rsp_fall_time   = rsp_fall_ff;

`ifndef SYNTH
   a_query_gives_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("query left the work stage without a result beat");

   a_stall_only_on_query: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_kind_ff == KIND_QUERY && rsp_valid_ff)
      else $error("input stalled without a blocked query");

   a_stalled_work_kept: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> s1_valid_ff && $stable(s1_index_ff))
      else $error("stalled query lost from work stage");
`endif

endmodule

>>> test/pin_edge_timestamp_capture_core_test.sv
`timescale 1ns / 1ps

typedef struct {
   pets_pkg::edge_status_type status;
   logic [31:0]               rise;
   logic [31:0]               fall;
} pin_report_type;

// tracks pin levels, per-pin status and stamps; queues the report each query returns
class edge_capture_scoreboard;
   localparam int PIN_COUNT = pets_pkg::PINS_PER_PORT * pets_pkg::DEF_PORT_COUNT;

   logic [PIN_COUNT-1:0]      last_levels;
   pets_pkg::edge_status_type edge_seen[PIN_COUNT];
   logic [31:0]               rise_at[PIN_COUNT];
   logic [31:0]               fall_at[PIN_COUNT];
   pin_report_type            awaited[$];
   int unsigned               errors;
   int unsigned               results_seen;

   function new();
      last_levels = '1;
      for (int p = 0; p < PIN_COUNT; p++) begin
         edge_seen[p] = pets_pkg::EDGE_NONE;
         rise_at[p]   = '0;
         fall_at[p]   = '0;
      end
      errors       = 0;
      results_seen = 0;
   endfunction

   function void note_beat(logic kind, logic [PIN_COUNT-1:0] levels, logic [31:0] now,
                           logic [4:0] index);
      logic [PIN_COUNT-1:0] toggled;
      int                   pin;
      pin_report_type       rep;
      if (kind == pets_pkg::KIND_SAMPLE) begin
         toggled     = levels ^ last_levels;
         last_levels = levels;
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (toggled[p]) begin
               if (levels[p]) begin
                  rise_at[p]   = now;
                  edge_seen[p] = pets_pkg::EDGE_RISE;
               end else begin
                  fall_at[p]   = now;
                  edge_seen[p] = pets_pkg::EDGE_FALL;
               end
            end
         end
      end else begin
         // indices past the last pin land on the last pin
         pin        = (index > PIN_COUNT - 1) ? PIN_COUNT - 1 : int'(index);
         rep.status = edge_seen[pin];
         rep.rise   = rise_at[pin];
         rep.fall   = fall_at[pin];
         awaited.push_back(rep);
         edge_seen[pin] = pets_pkg::EDGE_NONE;
      end
   endfunction

   function void check_result(logic [1:0] status, logic [31:0] rise, logic [31:0] fall);
      pin_report_type want;
      results_seen++;
      if (awaited.size() == 0) begin
         $error("unexpected result beat: edge_status %0d rise_time %h fall_time %h",
                status, rise, fall);
         errors++;
         return;
      end
      want = awaited.pop_front();
      if (status !== want.status) begin
         $error("edge_status: expected %0d, got %0d", want.status, status);
         errors++;
      end
      if (rise !== want.rise) begin
         $error("rise_time: expected %h, got %h", want.rise, rise);
         errors++;
      end
      if (fall !== want.fall) begin
         $error("fall_time: expected %h, got %h", want.fall, fall);
         errors++;
      end
   endfunction
endclass

module pin_edge_timestamp_capture_core_test;
   localparam int PIN_COUNT  = pets_pkg::PINS_PER_PORT * pets_pkg::DEF_PORT_COUNT;
   localparam int ITEMS      = 1150;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_OFF   = 300;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_kind = pets_pkg::KIND_SAMPLE;
   logic [PIN_COUNT-1:0]                 req_pin_levels = '1;
   logic [pets_pkg::NOW_TIME_W-1:0]      req_now_time = '0;
   logic [pets_pkg::PIN_INDEX_W-1:0]     req_pin_index = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [pets_pkg::STATUS_W-1:0]        rsp_edge_status;
   logic [pets_pkg::NOW_TIME_W-1:0]      rsp_rise_time;
   logic [pets_pkg::NOW_TIME_W-1:0]      rsp_fall_time;

   edge_capture_scoreboard sb = new();
   int unsigned            burst_left = 0;
   int unsigned            idle_cycles = 0;

   pin_edge_timestamp_capture_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pin_levels  (req_pin_levels),
      .req_now_time    (req_now_time),
      .req_pin_index   (req_pin_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_edge_status (rsp_edge_status),
      .rsp_rise_time   (rsp_rise_time),
      .rsp_fall_time   (rsp_fall_time)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // offers one beat in burst/gap fashion and holds it until taken
   task automatic send_beat(logic kind, logic [PIN_COUNT-1:0] levels, logic [31:0] now,
                            logic [4:0] index);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_pin_levels <= levels;
      req_now_time   <= now;
      req_pin_index  <= index;
      do @(posedge clock); while (req_stall);
      sb.note_beat(kind, levels, now, index);
   endtask

   task automatic send_sample(logic [PIN_COUNT-1:0] levels, logic [31:0] now);
      send_beat(pets_pkg::KIND_SAMPLE, levels, now, 5'($urandom));
   endtask

   task automatic send_query(logic [4:0] index);
      send_beat(pets_pkg::KIND_QUERY, PIN_COUNT'($urandom), $urandom, index);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_edge_status, rsp_rise_time, rsp_fall_time);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with one long hold-off so the block backs up
   initial begin
      int unsigned mode;
      int unsigned left;
      bit          held;
      mode = 0;
      left = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (!held && sb.results_seen >= 150) begin
            held = 1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(10, 60);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin
      logic [PIN_COUNT-1:0] lv;
      logic [31:0]          tick;
      int unsigned          sel;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset state, saturation, all-pin edges, repeated edges
      send_query(5'd0);
      send_query(5'd31);
      send_sample('1, 32'd5);
      send_query(5'd7);
      send_sample('0, 32'hffff_ffff);
      send_query(5'd0);
      send_query(5'd23);
      send_query(5'd0);
      send_beat(pets_pkg::KIND_SAMPLE, '1, 32'd0, 5'd31);
      send_sample(24'h00ff00, 32'h1234_5678);
      send_sample(24'hff00ff, 32'h9abc_def0);
      send_query(5'd8);
      send_query(5'd1);
      send_query(5'd16);
      send_query(5'd24);
      send_query(5'd30);
      send_sample(24'ha5a5a5, 32'h8000_0000);
      send_sample(24'h5a5a5a, 32'd1);
      send_query(5'd2);
      send_query(5'd3);
      send_query(5'd21);

      lv   = 24'h5a5a5a;
      tick = 32'd100;
      for (int n = 0; n < ITEMS; n++) begin
         if ($urandom_range(0, 4) < 2) begin
            send_query(($urandom_range(0, 5) == 0) ? 5'($urandom_range(24, 31))
                                                   : 5'($urandom_range(0, 23)));
         end else begin
            sel = $urandom_range(0, 9);
            case (sel) inside
               [0:3]: begin
                  repeat ($urandom_range(1, 3))
                     lv ^= PIN_COUNT'(1) << $urandom_range(0, PIN_COUNT - 1);
               end
               [4:5]: ;
               6: lv = PIN_COUNT'($urandom);
               7: lv = ($urandom_range(0, 1) == 0) ? '0 : '1;
               default: lv ^= PIN_COUNT'(8'hff) << (8 * $urandom_range(0, 2));
            endcase
            // mostly advancing stamps, now and then a jump anywhere
            if ($urandom_range(0, 19) == 0)
               tick = $urandom;
            else
               tick += $urandom_range(1, 1000);
            send_sample(lv, tick);
         end
      end
      req_valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
